// ===== hdl/crystal_energy_histogram_peak_norm_core_defines.svh =====
// assertion macros for the crystal energy histogram core
`ifndef CRYSTAL_ENERGY_HISTOGRAM_PEAK_NORM_CORE_DEFINES_SVH
`define CRYSTAL_ENERGY_HISTOGRAM_PEAK_NORM_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CEHPN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cehpn same-cycle check failed");

// next-cycle implication, checked outside reset
`define CEHPN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cehpn next-cycle check failed");

`endif

// ===== hdl/cehpn_pkg.sv =====
// shared types and constants of the crystal energy histogram core
package cehpn_pkg;

  localparam int REQ_W   = 2;
  localparam int BINW    = 10;
  localparam int CNT_W   = 32;
  localparam int FACT_W  = 23;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 72;

  // energy / 10 as multiply by reciprocal, exact for 16-bit energies
  localparam int EN_W    = 16;
  localparam logic [16:0] E_RECIP = 17'd52429;
  localparam int E_SHIFT = 19;
  localparam int EPROD_W = 33;

  // factor divider: (511 << 17) + d over 2d
  localparam int NUM_W   = 26;
  localparam int DEN_W   = 15;
  localparam logic [NUM_W-1:0] FACT_NUM = 26'd66977792;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EVENT   = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_DEC  = 16'h0004,
    S_ADR  = 16'h0008,
    S_PTAB = 16'h0010,
    S_SLOT = 16'h0020,
    S_VCHK = 16'h0040,
    S_ZERO = 16'h0080,
    S_OP   = 16'h0100,
    S_INC  = 16'h0200,
    S_RDW  = 16'h0400,
    S_SCAN = 16'h0800,
    S_SDRN = 16'h1000,
    S_DIVS = 16'h2000,
    S_DIVW = 16'h4000,
    S_RESP = 16'h8000
  } state_t;

endpackage

// ===== hdl/crystal_energy_histogram_peak_norm_core.sv =====
// top level: per-crystal energy histogram with photopeak factor
//
// channel  dir  fields
// s_*      in   tuser: req_type; tdata: module_id unit_id pos_x pos_y energy crystal_id bin_index
// m_*      out  tdata: status peak_bin factor count
//
// one transaction at a time, each paced by the single histogram ram port sequence
// the first touch of a crystal after reset adds zero writes over all BINS bins of its histogram
// after reset a clearing pass over all MODULES*UNITS*CRYSTALS valid flags runs before s_tready
// a stalled m_tready holds the finished result and the next transaction waits
module crystal_energy_histogram_peak_norm_core #(
  parameter int MODULES  = 4,
  parameter int UNITS    = 16,
  parameter int CRYSTALS = 256,
  parameter int POSITION = 64,
  parameter int BINS     = 1000
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // module_id, unit_id, pos_x, pos_y, energy, crystal_id, bin_index
  input  logic [cehpn_pkg::IN_W-1:0]   s_tdata,
  // req_type
  input  logic [cehpn_pkg::REQ_W-1:0]  s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status, peak_bin, factor, count, zero pad
  output logic [cehpn_pkg::OUT_W-1:0]  m_tdata
);
  import cehpn_pkg::*;

`include "crystal_energy_histogram_peak_norm_core_defines.svh"

  localparam int BASES = MODULES * UNITS;
  localparam int SLOTS = BASES * CRYSTALS;
  localparam int ROWS  = BASES * POSITION;
  localparam int TBL   = ROWS * POSITION;
  localparam int HDEP  = SLOTS * BINS;
  localparam int BASEW = (BASES > 1) ? $clog2(BASES) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TW    = (TBL > 1) ? $clog2(TBL) : 1;
  localparam int HW    = (HDEP > 1) ? $clog2(HDEP) : 1;

  state_t state;

  // latched request
  req_t        req;
  logic [1:0]  mod_id;
  logic [3:0]  unit_id;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] energy;
  logic [7:0]  crystal_id;
  logic [BINW-1:0] bin_index;

  logic [BASEW-1:0]   base;
  logic [RW-1:0]      row;
  logic [EPROD_W-1:0] eprod;
  logic               bad_mu;
  logic [SW-1:0]      slot;
  logic [HW-1:0]      hbase;
  logic [BINW-1:0]    ebin;
  logic [BINW-1:0]    zi;
  logic [SW-1:0]      clr_i;
  logic [BINW-1:0]    scan_i;
  logic [BINW-1:0]    pidx;
  logic               pend;
  logic [CNT_W-1:0]   maxc;
  logic [BINW-1:0]    rec;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  // result fields
  logic              r_status;
  logic [BINW-1:0]   r_peak;
  logic [FACT_W-1:0] r_factor;
  logic [CNT_W-1:0]  r_count;

  // memory ports
  logic [TW-1:0]    tix;
  logic             ptab_we;
  logic [7:0]       ptab_rdata;
  logic             vld_we;
  logic [SW-1:0]    vld_waddr;
  logic             vld_wdata;
  logic [0:0]       vld_rdata;
  logic             hist_we;
  logic [HW-1:0]    hist_waddr;
  logic [CNT_W-1:0] hist_wdata;
  logic [HW-1:0]    hist_raddr;
  logic [CNT_W-1:0] hist_rdata;
  logic [BINW-1:0]  hidx;

  logic [13:0] eb_full;
  logic        pos_bad;
  logic        load_ok;
  logic        accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign eb_full  = eprod[E_SHIFT +: 14];
  assign pos_bad  = (pos_x >= POSITION) || (pos_y >= POSITION);
  assign load_ok  = (state == S_ADR) && (req == REQ_LOAD) && !bad_mu && !pos_bad &&
                    (crystal_id < CRYSTALS);
  assign tix      = TW'(row * POSITION + pos_x);

  assign ptab_we = load_ok;

  assign vld_we    = (state == S_CLR) || ((state == S_ZERO) && (zi == BINW'(BINS - 1)));
  assign vld_waddr = (state == S_CLR) ? clr_i : slot;
  assign vld_wdata = (state != S_CLR);

  always_comb begin
    case (state)
      S_SCAN:  hidx = scan_i;
      default: hidx = (req == REQ_READ) ? bin_index : ebin;
    endcase
  end
  assign hist_raddr = hbase + HW'(hidx);
  assign hist_we    = (state == S_ZERO) || (state == S_INC);
  assign hist_waddr = hbase + HW'((state == S_ZERO) ? zi : ebin);
  // saturating increment
  assign hist_wdata = (state == S_ZERO) ? '0 :
                      ((hist_rdata == '1) ? hist_rdata : hist_rdata + 1'b1);

  cehpn_ram #(.WIDTH(8), .DEPTH(TBL)) u_ptab (
    .clk   (clk),
    .we    (ptab_we),
    .waddr (tix),
    .wdata (crystal_id),
    .raddr (tix),
    .rdata (ptab_rdata)
  );

  cehpn_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_vld (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .raddr (slot),
    .rdata (vld_rdata)
  );

  cehpn_ram #(.WIDTH(CNT_W), .DEPTH(HDEP)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  cehpn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_i     <= '0;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
      pend      <= 1'b0;
    end else begin
      div_start <= (state == S_DIVS);
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_i <= clr_i + 1'b1;
          if (clr_i == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_DEC;
          end
        end
        S_DEC: state <= S_ADR;
        S_ADR: begin
          if (bad_mu) begin
            state <= S_RESP;
          end else if (req == REQ_LOAD) begin
            state <= S_RESP;
          end else if (req == REQ_EVENT) begin
            state <= (pos_bad || (eb_full >= BINS)) ? S_RESP : S_PTAB;
          end else if (crystal_id >= CRYSTALS) begin
            state <= S_RESP;
          end else if ((req == REQ_READ) && (bin_index >= BINS)) begin
            state <= S_RESP;
          end else begin
            state <= S_SLOT;
          end
        end
        S_PTAB: state <= (ptab_rdata >= CRYSTALS) ? S_RESP : S_SLOT;
        S_SLOT: state <= S_VCHK;
        S_VCHK: state <= vld_rdata[0] ? S_OP : S_ZERO;
        S_ZERO: begin
          if (zi == BINW'(BINS - 1)) begin
            state <= S_OP;
          end
        end
        S_OP: begin
          pend <= 1'b0;
          case (req)
            REQ_EVENT:   state <= S_INC;
            REQ_READ:    state <= S_RDW;
            default:     state <= S_SCAN;
          endcase
        end
        S_INC: state <= S_RESP;
        S_RDW: state <= S_RESP;
        S_SCAN: begin
          pend <= 1'b1;
          if (scan_i == BINW'(BINS - 1)) begin
            state <= S_SDRN;
          end
        end
        S_SDRN: state <= S_DIVS;
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req        <= req_t'(s_tuser);
          mod_id     <= s_tdata[1:0];
          unit_id    <= s_tdata[5:2];
          pos_x      <= s_tdata[13:6];
          pos_y      <= s_tdata[21:14];
          energy     <= s_tdata[37:22];
          crystal_id <= s_tdata[45:38];
          bin_index  <= s_tdata[55:46];
          r_status   <= 1'b0;
          r_peak     <= '0;
          r_factor   <= '0;
          r_count    <= '0;
        end
      end
      S_DEC: begin
        bad_mu <= (mod_id >= MODULES) || (unit_id >= UNITS);
        base   <= BASEW'(mod_id * UNITS + unit_id);
        row    <= RW'((mod_id * UNITS + unit_id) * POSITION + pos_y);
        eprod  <= EPROD_W'(energy) * EPROD_W'(E_RECIP);
      end
      S_ADR: begin
        ebin <= eb_full[BINW-1:0];
        slot <= SW'(base * CRYSTALS + crystal_id);
        if (bad_mu) begin
          r_status <= 1'b1;
        end else if ((req == REQ_LOAD) || (req == REQ_EVENT)) begin
          if (pos_bad || ((req == REQ_LOAD) && (crystal_id >= CRYSTALS)) ||
              ((req == REQ_EVENT) && (eb_full >= BINS))) begin
            r_status <= 1'b1;
          end
        end else if ((crystal_id >= CRYSTALS) ||
                     ((req == REQ_READ) && (bin_index >= BINS))) begin
          r_status <= 1'b1;
        end
      end
      S_PTAB: begin
        slot <= SW'(base * CRYSTALS + ptab_rdata);
        if (ptab_rdata >= CRYSTALS) begin
          r_status <= 1'b1;
        end
      end
      S_SLOT: begin
        hbase <= HW'(slot * BINS);
        zi    <= '0;
      end
      S_ZERO: zi <= zi + 1'b1;
      S_OP: begin
        scan_i <= '0;
        maxc   <= '0;
        rec    <= '0;
      end
      S_RDW: r_count <= hist_rdata;
      S_SCAN: begin
        pidx   <= scan_i;
        scan_i <= scan_i + 1'b1;
        // keep the last bin holding the maximum
        if (pend && (maxc <= hist_rdata)) begin
          maxc <= hist_rdata;
          rec  <= pidx;
        end
      end
      S_SDRN: begin
        if (maxc <= hist_rdata) begin
          maxc <= hist_rdata;
          rec  <= pidx;
        end
      end
      S_DIVS: begin
        div_num <= FACT_NUM + NUM_W'(rec * 10 + 5);
        div_den <= DEN_W'((rec * 10 + 5) * 2);
      end
      S_DIVW: begin
        if (div_done) begin
          r_factor <= div_quot[FACT_W-1:0];
          r_peak   <= rec;
          r_count  <= maxc;
        end
      end
      S_RESP: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {6'd0, r_count, r_factor, r_peak, r_status};
        end
      end
      default: ;
    endcase
  end

  `CEHPN_ASSERT_IMP(a_div_done_in_wait, div_done, state == S_DIVW)
  `CEHPN_ASSERT_NXT(a_accept_decodes, accept, (state == S_DEC) && !s_tready)
  `CEHPN_ASSERT_IMP(a_zero_sweep_bound, state == S_ZERO, zi < BINS)
  `CEHPN_ASSERT_NXT(a_resp_delivers, (state == S_RESP) && (!m_tvalid || m_tready),
                    m_tvalid && (state == S_IDLE))

endmodule

// ===== hdl/cehpn_ram.sv =====
// generic simple dual-port ram with registered read
module cehpn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cehpn_div.sv =====
// restoring divider, one quotient bit per cycle
module cehpn_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cehpn_pkg::NUM_W-1:0] num,
  input  logic [cehpn_pkg::DEN_W-1:0] den,
  output logic                        done,
  output logic [cehpn_pkg::NUM_W-1:0] quot
);
  import cehpn_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W:0]       trial;
  logic                 take;

  assign trial = {rem, quot[NUM_W-1]};
  assign take  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], take};
      rem  <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

endmodule

// ===== sim/tb_crystal_energy_histogram_peak_norm_core.sv =====
// testbench for the crystal energy histogram core: directed and random traffic against a predictor
module tb_crystal_energy_histogram_peak_norm_core;
  timeunit 1ns;
  timeprecision 1ps;
  import cehpn_pkg::*;

  localparam int NUM_MODULES  = 4;
  localparam int NUM_UNITS    = 16;
  localparam int NUM_CRYSTALS = 256;
  localparam int GRID         = 64;
  localparam int NUM_BINS     = 1000;
  localparam int STALL_LIMIT  = 60000;
  localparam int RANDOM_ITEMS = 1930;

  typedef struct {
    req_t        req;
    logic [1:0]  module_id;
    logic [3:0]  unit_id;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] energy;
    logic [7:0]  crystal_id;
    logic [9:0]  bin_index;
  } request_t;

  typedef struct {
    logic        status;
    logic [9:0]  peak_bin;
    logic [22:0] factor;
    logic [31:0] count;
  } answer_t;

  typedef struct {
    logic [1:0] module_id;
    logic [3:0] unit_id;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
  } place_t;

  logic           clk;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [REQ_W-1:0] s_tuser;
  logic           m_tvalid;
  logic           m_tready;
  logic [OUT_W-1:0] m_tdata;

  // predictor state: sparse bin counters and crystal map
  logic [31:0] bin_counts [int unsigned];
  logic [7:0]  crystal_map [int unsigned];
  place_t      loaded_places [$];
  answer_t     pending_answers [$];

  int mismatches;
  int idle_cycles;
  int burst_left;
  int cycle_no;
  int stall_mode;

  crystal_energy_histogram_peak_norm_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int unsigned bin_key(int unsigned slot, int unsigned b);
    return slot * NUM_BINS + b;
  endfunction

  function automatic answer_t histogram_answer(request_t r);
    answer_t a;
    int unsigned base, tix, slot, b, maxc, peak;
    longint unsigned d;
    logic [31:0] c;
    a = '{default: '0};
    base = r.module_id * NUM_UNITS + r.unit_id;
    if (r.module_id >= NUM_MODULES || r.unit_id >= NUM_UNITS) begin
      a.status = 1'b1;
    end else if (r.req == REQ_LOAD || r.req == REQ_EVENT) begin
      if (r.pos_x >= GRID || r.pos_y >= GRID) begin
        a.status = 1'b1;
      end else begin
        tix = (base * GRID + r.pos_y) * GRID + r.pos_x;
        if (r.req == REQ_LOAD) begin
          if (r.crystal_id >= NUM_CRYSTALS) a.status = 1'b1;
          else crystal_map[tix] = r.crystal_id;
        end else begin
          b = r.energy / 10;
          if (!crystal_map.exists(tix) || b >= NUM_BINS) begin
            a.status = 1'b1;
          end else begin
            slot = base * NUM_CRYSTALS + crystal_map[tix];
            c = bin_counts.exists(bin_key(slot, b)) ? bin_counts[bin_key(slot, b)] : 32'd0;
            if (c != 32'hFFFF_FFFF) c = c + 32'd1;
            bin_counts[bin_key(slot, b)] = c;
          end
        end
      end
    end else if (r.crystal_id >= NUM_CRYSTALS) begin
      a.status = 1'b1;
    end else if (r.req == REQ_COMPUTE) begin
      slot = base * NUM_CRYSTALS + r.crystal_id;
      maxc = 0;
      peak = 0;
      for (int i = 0; i < NUM_BINS; i++) begin
        c = bin_counts.exists(bin_key(slot, i)) ? bin_counts[bin_key(slot, i)] : 32'd0;
        if (maxc <= c) begin
          maxc = c;
          peak = i;
        end
      end
      d = longint'(peak) * 10 + 5;
      a.peak_bin = peak[9:0];
      a.factor = 23'(((64'd511 << 17) + d) / (2 * d));
      a.count = maxc;
    end else begin
      slot = base * NUM_CRYSTALS + r.crystal_id;
      if (r.bin_index >= NUM_BINS) a.status = 1'b1;
      else if (bin_counts.exists(bin_key(slot, r.bin_index)))
        a.count = bin_counts[bin_key(slot, r.bin_index)];
    end
    return a;
  endfunction

  // one transaction on the slave side; the sender sometimes idles between bursts
  task automatic send_request(request_t r);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= r.req;
    s_tdata  <= {r.bin_index, r.crystal_id, r.energy, r.pos_y, r.pos_x, r.unit_id,
                 r.module_id};
    do @(posedge clk); while (!s_tready);
    pending_answers.push_back(histogram_answer(r));
    if (r.req == REQ_LOAD && r.pos_x < GRID && r.pos_y < GRID)
      loaded_places.push_back('{r.module_id, r.unit_id, r.pos_x, r.pos_y});
  endtask

  function automatic request_t make_request(req_t kind);
    request_t r;
    r.req        = kind;
    r.module_id  = 2'($urandom_range(0, 3));
    r.unit_id    = 4'($urandom_range(0, 15));
    r.pos_x      = 8'($urandom_range(0, 255));
    r.pos_y      = 8'($urandom_range(0, 255));
    r.energy     = 16'($urandom);
    r.crystal_id = 8'($urandom);
    r.bin_index  = 10'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] pick_crystal();
    return ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 5));
  endfunction

  // event on a loaded place, or on an out-of-range position
  function automatic request_t make_event(int unsigned lo, int unsigned hi);
    request_t r;
    place_t p;
    r = make_request(REQ_EVENT);
    if (loaded_places.size() == 0 || $urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1)) r.pos_x = 8'($urandom_range(GRID, 255));
      else r.pos_y = 8'($urandom_range(GRID, 255));
      return r;
    end
    p = loaded_places[$urandom_range(0, loaded_places.size() - 1)];
    r.module_id = p.module_id;
    r.unit_id   = p.unit_id;
    r.pos_x     = p.pos_x;
    r.pos_y     = p.pos_y;
    case ($urandom_range(0, 9))
      0, 1:    r.energy = 16'($urandom_range(0, 9999));
      2:       r.energy = 16'($urandom);
      default: r.energy = 16'($urandom_range(lo, hi));
    endcase
    return r;
  endfunction

  function automatic request_t make_load();
    request_t r;
    r = make_request(REQ_LOAD);
    r.unit_id    = 4'($urandom_range(0, 15) < 12 ? $urandom_range(0, 1) : $urandom_range(0, 15));
    r.crystal_id = pick_crystal();
    if ($urandom_range(0, 19) != 0) begin
      r.pos_x = 8'($urandom_range(0, GRID - 1));
      r.pos_y = 8'($urandom_range(0, GRID - 1));
    end
    return r;
  endfunction

  // query mostly aimed at a module and unit that have seen loads, when there is one
  function automatic request_t make_query(req_t kind);
    request_t r;
    place_t p;
    r = make_request(kind);
    if (loaded_places.size() > 0 && $urandom_range(0, 4) != 0) begin
      p = loaded_places[$urandom_range(0, loaded_places.size() - 1)];
      r.module_id  = p.module_id;
      r.unit_id    = p.unit_id;
      r.crystal_id = pick_crystal();
    end
    if (kind == REQ_READ && $urandom_range(0, 19) != 0)
      r.bin_index = 10'($urandom_range(0, 3) == 0 ? $urandom_range(0, 999)
                                                  : $urandom_range(400, 560));
    return r;
  endfunction

  task automatic test_load_edges();
    request_t r;
    r = make_request(REQ_LOAD);
    r.module_id = 2'd3; r.unit_id = 4'd15; r.pos_x = 8'd63; r.pos_y = 8'd63;
    r.crystal_id = 8'hFF;
    send_request(r);
    r.module_id = 2'd0; r.unit_id = 4'd0; r.pos_x = 8'd0; r.pos_y = 8'd0;
    r.crystal_id = 8'd0;
    send_request(r);
    r.pos_x = 8'd64;
    send_request(r);
    r.pos_x = 8'd5; r.pos_y = 8'd255;
    send_request(r);
  endtask

  task automatic test_event_edges();
    request_t r;
    r = make_request(REQ_EVENT);
    r.module_id = 2'd3; r.unit_id = 4'd15; r.pos_x = 8'd63; r.pos_y = 8'd63;
    r.energy = 16'd0;
    send_request(r);
    r.energy = 16'd9999;
    send_request(r);
    send_request(r);
    r.energy = 16'd10000;
    send_request(r);
    r.energy = 16'hFFFF;
    send_request(r);
    r.pos_x = 8'd200;
    send_request(r);
    r.module_id = 2'd0; r.unit_id = 4'd0; r.pos_x = 8'd0; r.pos_y = 8'd0;
    r.energy = 16'd4999;
    send_request(r);
  endtask

  task automatic test_read_edges();
    request_t r;
    r = make_request(REQ_READ);
    r.module_id = 2'd3; r.unit_id = 4'd15; r.crystal_id = 8'hFF;
    r.bin_index = 10'd0;
    send_request(r);
    r.bin_index = 10'd999;
    send_request(r);
    r.bin_index = 10'd1000;
    send_request(r);
    r.bin_index = 10'd1023;
    send_request(r);
  endtask

  task automatic test_compute_edges();
    request_t r;
    r = make_request(REQ_COMPUTE);
    // untouched crystal: flat histogram peaks at the last bin
    r.module_id = 2'd1; r.unit_id = 4'd7; r.crystal_id = 8'd9;
    send_request(r);
    r.module_id = 2'd3; r.unit_id = 4'd15; r.crystal_id = 8'hFF;
    send_request(r);
    r.module_id = 2'd0; r.unit_id = 4'd0; r.crystal_id = 8'd0;
    send_request(r);
  endtask

  task automatic test_random_traffic();
    request_t r;
    int unsigned k;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      k = $urandom_range(0, 99);
      if (k < 15)      r = make_load();
      else if (k < 75) r = make_event(4300 + 500 * (i / 700), 4800 + 500 * (i / 700));
      else if (k < 80) r = make_query(REQ_COMPUTE);
      else             r = make_query(REQ_READ);
      send_request(r);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // receiver stall pattern, switching between modes
  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 0);
      2:       m_tready <= (cycle_no % 5 != 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    answer_t exp_a, got;
    if (!rst && m_tvalid && m_tready) begin
      got.status   = m_tdata[0];
      got.peak_bin = m_tdata[10:1];
      got.factor   = m_tdata[33:11];
      got.count    = m_tdata[65:34];
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", m_tdata);
      end else begin
        exp_a = pending_answers.pop_front();
        if (got != exp_a) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch status %0d/%0d peak %0d/%0d factor %0d/%0d count %0d/%0d",
                     exp_a.status, got.status, exp_a.peak_bin, got.peak_bin,
                     exp_a.factor, got.factor, exp_a.count, got.count);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_crystal_energy_histogram_peak_norm_core: FAIL");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    m_tready    = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    cycle_no    = 0;
    stall_mode  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_load_edges();
    test_event_edges();
    test_read_edges();
    test_compute_edges();
    test_random_traffic();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("tb_crystal_energy_histogram_peak_norm_core: PASS");
    end else begin
      $display("tb_crystal_energy_histogram_peak_norm_core: FAIL");
    end
    $finish;
  end

endmodule
